// ===== design/temporal_earliest_arrival_defines.svh =====
// ----------------------------------------------------------------------------
// temporal earliest arrival assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_EARLIEST_ARRIVAL_DEFINES_SVH
`define TEMPORAL_EARLIEST_ARRIVAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TEA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TEA_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TEA_ASSERT(lbl, clk, rst, prop, msg)
`define TEA_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== design/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// shared types and constants of the temporal earliest arrival block
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int VTX_W      = 10;
   localparam int TIME_W     = 31;
   localparam int END_W      = 32;
   localparam int MODE_W     = 2;
   localparam int EPOCH_W    = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   localparam logic [1:0] REG_SOURCE_VERTEX = 2'd0;
   localparam logic [1:0] REG_WINDOW_START  = 2'd1;
   localparam logic [1:0] REG_WINDOW_END    = 2'd2;

   localparam logic [TIME_W-1:0] WINDOW_END_RESET = 31'h7fff_ffff;

   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hff;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [VTX_W-1:0]  source_vertex;
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] window_end;
   } cfg_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [TIME_W-1:0]  arrival;
   } entry_type;

endpackage

// ===== design/tea_ram.sv =====
// ----------------------------------------------------------------------------
// tea_ram
// generic ram, one write port, two registered read ports, old data on collision
// ----------------------------------------------------------------------------
module tea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic                     re_b,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a_ff <= mem_ff[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== design/tea_csr.sv =====
// ----------------------------------------------------------------------------
// tea_csr
// apb register file: source vertex, window start, window end
// ----------------------------------------------------------------------------
module tea_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output tea_pkg::cfg_type                 cfg
);

   logic [tea_pkg::VTX_W-1:0]  source_ff;
   logic [tea_pkg::TIME_W-1:0] start_ff;
   logic [tea_pkg::TIME_W-1:0] end_ff;
   logic                       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         start_ff  <= '0;
         end_ff    <= tea_pkg::WINDOW_END_RESET;
      end else if (wr_en) begin
         case (paddr[3:2])
            tea_pkg::REG_SOURCE_VERTEX: source_ff <= pwdata[tea_pkg::VTX_W-1:0];
            tea_pkg::REG_WINDOW_START:  start_ff  <= pwdata[tea_pkg::TIME_W-1:0];
            tea_pkg::REG_WINDOW_END:    end_ff    <= pwdata[tea_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         tea_pkg::REG_SOURCE_VERTEX: prdata = 32'(source_ff);
         tea_pkg::REG_WINDOW_START:  prdata = 32'(start_ff);
         tea_pkg::REG_WINDOW_END:    prdata = 32'(end_ff);
         default:                    prdata = '0;
      endcase
   end

   assign cfg.source_vertex = source_ff;
   assign cfg.window_start  = start_ff;
   assign cfg.window_end    = end_ff;

endmodule

// ===== design/temporal_earliest_arrival.sv =====
// throughput: one request beat per cycle while results are taken and no sweep runs
// a taken request beat is held in the update stage register with its arrival memory read,
//   then update and write back, and the result goes to the output register
// a restart that exhausts the 8-bit pass tag sweeps the memory first
// reset: synchronous; a sweep clears the memory, req_ready low meanwhile
// ----------------------------------------------------------------------------
// temporal_earliest_arrival
// one-pass earliest arrival over a departure-sorted temporal edge stream,
// arrival times and pass tags held in one ram, read-modify-write with forwarding
// ----------------------------------------------------------------------------
`include "temporal_earliest_arrival_defines.svh"

module temporal_earliest_arrival #(
   parameter int VERTICES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tea_pkg::MODE_W-1:0]       req_mode,
   input  logic [tea_pkg::VTX_W-1:0]        req_from_vertex,
   input  logic [tea_pkg::VTX_W-1:0]        req_to_vertex,
   input  logic [tea_pkg::TIME_W-1:0]       req_depart_time,
   input  logic [tea_pkg::TIME_W-1:0]       req_duration,
   input  logic [tea_pkg::VTX_W-1:0]        req_query_vertex,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_reached,
   output logic [tea_pkg::TIME_W-1:0]       rsp_arrival_time,
   output logic                             rsp_improved,
   output logic                             rsp_closed,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int AW = $clog2(VERTICES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);
   localparam int ENTRY_W = $bits(tea_pkg::entry_type);

   typedef struct packed {
      logic [tea_pkg::MODE_W-1:0]  mode;
      logic [AW-1:0]               addr_b;
      logic                        ok_a;
      logic                        ok_b;
      logic [tea_pkg::TIME_W-1:0]  depart;
      logic [tea_pkg::END_W-1:0]   end_sum;
      logic                        end_ok;
      logic                        close_hit;
      logic [tea_pkg::EPOCH_W-1:0] epoch;
      logic                        fwd_a;
      logic                        fwd_b;
      tea_pkg::entry_type          fwd_data;
   } stage_type;

   tea_pkg::cfg_type   cfg;
   tea_pkg::state_type state_ff, state_in;

   logic [AW-1:0]               clr_cnt_ff, clr_cnt_in;
   logic                        seed_en_ff, seed_en_in;
   logic [tea_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                        closed_ff, closed_in;
   logic                        p1_valid_ff, p1_valid_in;
   logic                        p1_wrap_ff, p1_wrap_in;
   stage_type                   p1_ff, p1_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_reached_ff, rsp_reached_in;
   logic [tea_pkg::TIME_W-1:0]  rsp_arrival_ff, rsp_arrival_in;
   logic                        rsp_improved_ff, rsp_improved_in;
   logic                        rsp_closed_ff, rsp_closed_in;

   logic [31:0]                 from_ext, to_ext, query_ext, src_ext;
   logic                        accept, is_query, is_restart;
   logic [AW-1:0]               rd_addr_a, rd_addr_b, src_addr;
   logic                        rd_ok_a, rd_ok_b, src_ok;
   logic [tea_pkg::END_W-1:0]   end_sum;
   logic [tea_pkg::EPOCH_W-1:0] epoch_next;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   tea_pkg::entry_type          ram_wdata;
   logic [ENTRY_W-1:0]          ram_rdata_a, ram_rdata_b;
   tea_pkg::entry_type          ent_a, ent_b;

   logic out_space, p1_retire, clear_done;
   logic reached_a, reached_b, relax, improved, query_hit, wr_req;

   tea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tea_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VERTICES)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .re_a    (accept),
      .raddr_a (rd_addr_a),
      .rdata_a (ram_rdata_a),
      .re_b    (accept),
      .raddr_b (rd_addr_b),
      .rdata_b (ram_rdata_b)
   );

   // request side: addresses, range checks, end time
   assign from_ext   = 32'(req_from_vertex);
   assign to_ext     = 32'(req_to_vertex);
   assign query_ext  = 32'(req_query_vertex);
   assign src_ext    = 32'(cfg.source_vertex);
   assign src_addr   = src_ext[AW-1:0];
   assign src_ok     = src_ext < 32'(VERTICES);
   assign is_query   = req_mode == tea_pkg::MODE_QUERY;
   assign is_restart = req_mode == tea_pkg::MODE_RESTART;
   assign rd_addr_a  = is_query ? query_ext[AW-1:0] : from_ext[AW-1:0];
   assign rd_ok_a    = is_query ? (query_ext < 32'(VERTICES)) : (from_ext < 32'(VERTICES));
   assign rd_addr_b  = is_restart ? src_addr : to_ext[AW-1:0];
   assign rd_ok_b    = is_restart ? src_ok : (to_ext < 32'(VERTICES));
   assign end_sum    = {1'b0, req_depart_time} + {1'b0, req_duration};

   always_comb begin
      epoch_next = epoch_ff;
      if (is_restart) begin
         epoch_next = (epoch_ff == tea_pkg::EPOCH_LAST) ? tea_pkg::EPOCH_FIRST
                                                         : epoch_ff + tea_pkg::EPOCH_FIRST;
      end
   end

   assign out_space  = !rsp_valid_ff | rsp_ready;
   assign p1_retire  = (state_ff == tea_pkg::ST_RUN) & p1_valid_ff & !p1_wrap_ff & out_space;
   assign req_ready  = (state_ff == tea_pkg::ST_RUN) & (!p1_valid_ff | p1_retire);
   assign accept     = req_valid & req_ready;
   assign clear_done = (state_ff == tea_pkg::ST_CLEAR) & (clr_cnt_ff == LAST_ADDR);

   // update stage: forwarded entries, relax test
   assign ent_a = p1_ff.fwd_a ? p1_ff.fwd_data : tea_pkg::entry_type'(ram_rdata_a);
   assign ent_b = p1_ff.fwd_b ? p1_ff.fwd_data : tea_pkg::entry_type'(ram_rdata_b);

   assign reached_a = ent_a.epoch == p1_ff.epoch;
   assign reached_b = ent_b.epoch == p1_ff.epoch;
   assign relax     = (p1_ff.mode == tea_pkg::MODE_EDGE) & !closed_ff & p1_ff.ok_a
                    & p1_ff.ok_b & reached_a & p1_ff.end_ok
                    & (p1_ff.depart >= ent_a.arrival);
   assign improved  = relax & (!reached_b | (p1_ff.end_sum < {1'b0, ent_b.arrival}));
   assign query_hit = (p1_ff.mode == tea_pkg::MODE_QUERY) & p1_ff.ok_a & reached_a;
   assign wr_req    = improved | ((p1_ff.mode == tea_pkg::MODE_RESTART) & p1_ff.ok_b);

   always_comb begin
      case (p1_ff.mode)
         tea_pkg::MODE_EDGE:    closed_in = closed_ff | p1_ff.close_hit;
         tea_pkg::MODE_RESTART: closed_in = 1'b0;
         default:               closed_in = closed_ff;
      endcase
      if (!p1_retire) begin
         closed_in = closed_ff;
      end
   end

   // sweep control and memory write
   always_comb begin
      state_in          = state_ff;
      clr_cnt_in        = clr_cnt_ff;
      seed_en_in        = seed_en_ff;
      ram_we            = 1'b0;
      ram_waddr         = p1_ff.addr_b;
      ram_wdata.epoch   = p1_ff.epoch;
      ram_wdata.arrival = (p1_ff.mode == tea_pkg::MODE_EDGE)
                        ? p1_ff.end_sum[tea_pkg::TIME_W-1:0] : cfg.window_start;
      case (state_ff)
         tea_pkg::ST_CLEAR: begin
            ram_we            = 1'b1;
            ram_waddr         = clr_cnt_ff;
            ram_wdata.epoch   = (seed_en_ff && src_ok && clr_cnt_ff == src_addr)
                              ? tea_pkg::EPOCH_FIRST : tea_pkg::EPOCH_NONE;
            ram_wdata.arrival = cfg.window_start;
            clr_cnt_in        = clr_cnt_ff + AW'(1);
            if (clear_done) begin
               state_in   = tea_pkg::ST_RUN;
               clr_cnt_in = '0;
               seed_en_in = 1'b0;
            end
         end
         tea_pkg::ST_RUN: begin
            if (p1_valid_ff && p1_wrap_ff) begin
               state_in   = tea_pkg::ST_CLEAR;
               seed_en_in = 1'b1;
            end else if (p1_retire && wr_req) begin
               ram_we = 1'b1;
            end
         end
         default: begin
            state_in = tea_pkg::ST_CLEAR;
         end
      endcase
   end

   // pipeline register and result register
   always_comb begin
      p1_valid_in = p1_valid_ff;
      p1_wrap_in  = p1_wrap_ff;
      p1_in       = p1_ff;
      epoch_in    = epoch_ff;
      if (p1_retire) begin
         p1_valid_in = 1'b0;
      end
      if (clear_done) begin
         p1_wrap_in = 1'b0;
      end
      if (accept) begin
         p1_valid_in       = 1'b1;
         p1_wrap_in        = is_restart & (epoch_ff == tea_pkg::EPOCH_LAST);
         epoch_in          = epoch_next;
         p1_in.mode        = req_mode;
         p1_in.addr_b      = rd_addr_b;
         p1_in.ok_a        = rd_ok_a;
         p1_in.ok_b        = rd_ok_b;
         p1_in.depart      = req_depart_time;
         p1_in.end_sum     = end_sum;
         p1_in.end_ok      = end_sum <= {1'b0, cfg.window_end};
         p1_in.close_hit   = req_depart_time >= cfg.window_end;
         p1_in.epoch       = epoch_next;
         p1_in.fwd_a       = ram_we & (ram_waddr == rd_addr_a);
         p1_in.fwd_b       = ram_we & (ram_waddr == rd_addr_b);
         p1_in.fwd_data    = ram_wdata;
      end

      rsp_valid_in    = rsp_valid_ff & !rsp_ready;
      rsp_reached_in  = rsp_reached_ff;
      rsp_arrival_in  = rsp_arrival_ff;
      rsp_improved_in = rsp_improved_ff;
      rsp_closed_in   = rsp_closed_ff;
      if (p1_retire) begin
         rsp_valid_in    = 1'b1;
         rsp_reached_in  = query_hit;
         rsp_arrival_in  = query_hit ? ent_a.arrival : '0;
         rsp_improved_in = improved;
         rsp_closed_in   = closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tea_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         seed_en_ff   <= 1'b0;
         epoch_ff     <= tea_pkg::EPOCH_FIRST;
         closed_ff    <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p1_wrap_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         seed_en_ff   <= seed_en_in;
         epoch_ff     <= epoch_in;
         closed_ff    <= closed_in;
         p1_valid_ff  <= p1_valid_in;
         p1_wrap_ff   <= p1_wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff           <= p1_in;
      rsp_reached_ff  <= rsp_reached_in;
      rsp_arrival_ff  <= rsp_arrival_in;
      rsp_improved_ff <= rsp_improved_in;
      rsp_closed_ff   <= rsp_closed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reached      = rsp_reached_ff;
   assign rsp_arrival_time = rsp_arrival_ff;
   assign rsp_improved     = rsp_improved_ff;
   assign rsp_closed       = rsp_closed_ff;

   `TEA_NEVER(a_no_accept_in_clear, clock, reset, state_ff == tea_pkg::ST_CLEAR && req_ready, "request taken during memory sweep")
   `TEA_NEVER(a_epoch_valid, clock, reset, epoch_ff == tea_pkg::EPOCH_NONE, "pass tag holds the never-reached code")
   `TEA_ASSERT(a_sweep_runs, clock, reset, state_ff == tea_pkg::ST_CLEAR && clr_cnt_ff != LAST_ADDR |=> state_ff == tea_pkg::ST_CLEAR, "memory sweep ended early")
   `TEA_ASSERT(a_no_write_on_stall, clock, reset, state_ff == tea_pkg::ST_RUN && p1_valid_ff && !p1_retire |-> !ram_we, "memory written while update stage stalled")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: temporal earliest arrival testbench
// Feeds edge, query and restart beats over valid/ready and programs the window
// over the APB port. A local copy of the per-vertex arrival and reached state
// predicts every result beat, and each beat is compared field by field in
// order. The random part walks departure-sorted edges over small vertex pools,
// so paths grow, the stream closes and restarts reopen it. A burst of restarts
// runs through the pass tag, and the receiver and sender idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                            VTX_COUNT   = 1024;
   localparam logic [tea_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [tea_pkg::TIME_W-1:0]    TIME_TOP    = 31'h7fff_ffff;
   localparam int                            QUIET_LIMIT = 20000;
   localparam int                            LONG_STALL  = 400;

   typedef struct packed {
      logic [tea_pkg::MODE_W-1:0] mode;
      logic [tea_pkg::VTX_W-1:0]  from_v;
      logic [tea_pkg::VTX_W-1:0]  to_v;
      logic [tea_pkg::TIME_W-1:0] depart;
      logic [tea_pkg::TIME_W-1:0] duration;
      logic [tea_pkg::VTX_W-1:0]  query_v;
   } stream_item_type;

   typedef struct packed {
      logic                       reached;
      logic [tea_pkg::TIME_W-1:0] arrival;
      logic                       improved;
      logic                       closed;
   } answer_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [tea_pkg::MODE_W-1:0]         req_mode = '0;
   logic [tea_pkg::VTX_W-1:0]          req_from_vertex = '0;
   logic [tea_pkg::VTX_W-1:0]          req_to_vertex = '0;
   logic [tea_pkg::TIME_W-1:0]         req_depart_time = '0;
   logic [tea_pkg::TIME_W-1:0]         req_duration = '0;
   logic [tea_pkg::VTX_W-1:0]          req_query_vertex = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_reached;
   logic [tea_pkg::TIME_W-1:0]         rsp_arrival_time;
   logic                               rsp_improved;
   logic                               rsp_closed;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [tea_pkg::CSR_ADDR_W-1:0]     paddr = '0;
   logic [tea_pkg::CSR_DATA_W-1:0]     pwdata = '0;
   logic [tea_pkg::CSR_DATA_W-1:0]     prdata;
   logic                               pready;

   // predicted block state
   logic [tea_pkg::TIME_W-1:0] arr_mem [VTX_COUNT];
   bit                         reach_mem [VTX_COUNT];
   bit                         closed_now = 1'b0;
   logic [tea_pkg::VTX_W-1:0]  src_vtx = '0;
   logic [tea_pkg::TIME_W-1:0] win_start = '0;
   logic [tea_pkg::TIME_W-1:0] win_end = tea_pkg::WINDOW_END_RESET;

   stream_item_type stream_items [$];
   answer_type      pending_answers [$];

   logic req_took = 1'b0;
   int   tx_wait = 0;
   int   rx_wait = 0;
   bit   tx_idle_en = 1'b1;
   bit   rx_idle_en = 1'b1;
   int   long_stall_asks = 0;
   int   long_stall_done = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;

   temporal_earliest_arrival #(.VERTICES(VTX_COUNT)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_depart_time  (req_depart_time),
      .req_duration     (req_duration),
      .req_query_vertex (req_query_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reached      (rsp_reached),
      .rsp_arrival_time (rsp_arrival_time),
      .rsp_improved     (rsp_improved),
      .rsp_closed       (rsp_closed),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // earliest arrival update for one beat
   task automatic relax_and_answer(input stream_item_type it, output answer_type ans);
      logic [tea_pkg::END_W-1:0] finish_t;
      ans = '0;
      case (it.mode)
         tea_pkg::MODE_EDGE: begin
            if (!closed_now) begin
               finish_t = {1'b0, it.depart} + {1'b0, it.duration};
               if (reach_mem[it.from_v] && finish_t <= {1'b0, win_end} &&
                   it.depart >= arr_mem[it.from_v]) begin
                  if (!reach_mem[it.to_v] || finish_t < {1'b0, arr_mem[it.to_v]}) begin
                     arr_mem[it.to_v]   = finish_t[tea_pkg::TIME_W-1:0];
                     reach_mem[it.to_v] = 1'b1;
                     ans.improved       = 1'b1;
                  end
               end
               if (it.depart >= win_end)
                  closed_now = 1'b1;
            end
         end
         tea_pkg::MODE_QUERY: begin
            if (reach_mem[it.query_v]) begin
               ans.reached = 1'b1;
               ans.arrival = arr_mem[it.query_v];
            end
         end
         tea_pkg::MODE_RESTART: begin
            foreach (reach_mem[i])
               reach_mem[i] = 1'b0;
            closed_now        = 1'b0;
            arr_mem[src_vtx]   = win_start;
            reach_mem[src_vtx] = 1'b1;
         end
         default: ;
      endcase
      ans.closed = closed_now;
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [tea_pkg::VTX_W-1:0] rand_vtx();
      logic [31:0] r;
      r = $urandom_range(0, VTX_COUNT - 1);
      return r[tea_pkg::VTX_W-1:0];
   endfunction

   function automatic logic [tea_pkg::TIME_W-1:0] rand_time(input int unsigned lo,
                                                            input int unsigned hi);
      logic [31:0] r;
      r = $urandom_range(lo, hi);
      return r[tea_pkg::TIME_W-1:0];
   endfunction

   function automatic stream_item_type rand_item();
      stream_item_type it;
      logic [31:0]     r;
      r           = $urandom_range(0, 3);
      it.mode     = r[tea_pkg::MODE_W-1:0];
      it.from_v   = rand_vtx();
      it.to_v     = rand_vtx();
      r           = $urandom;
      it.depart   = r[tea_pkg::TIME_W-1:0];
      r           = $urandom;
      it.duration = r[tea_pkg::TIME_W-1:0];
      it.query_v  = rand_vtx();
      return it;
   endfunction

   function automatic void push_item(input logic [tea_pkg::MODE_W-1:0] mode,
                                     input logic [tea_pkg::VTX_W-1:0] from_v,
                                     input logic [tea_pkg::VTX_W-1:0] to_v,
                                     input logic [tea_pkg::TIME_W-1:0] depart,
                                     input logic [tea_pkg::TIME_W-1:0] duration,
                                     input logic [tea_pkg::VTX_W-1:0] query_v);
      stream_item_type it;
      it = '{mode, from_v, to_v, depart, duration, query_v};
      stream_items.push_back(it);
   endfunction

   // departure-sorted edges over a small vertex pool, with queries, restarts and noise
   task automatic gen_walk(input int count, input int pool_n);
      logic [tea_pkg::VTX_W-1:0] pool [32];
      longint                    t;
      longint                    span;
      longint                    dep;
      int                        r;
      int                        k;
      stream_item_type           it;
      pool[0] = src_vtx;
      for (k = 1; k < pool_n; k++)
         pool[k] = rand_vtx();
      span = (win_end > win_start) ? longint'(win_end) - longint'(win_start) : longint'(1);
      t = longint'(win_start);
      for (k = 0; k < count; k++) begin
         it = rand_item();
         r  = $urandom_range(0, 99);
         if (r < 8) begin
            it.mode = tea_pkg::MODE_RESTART;
            t = longint'(win_start);
         end else if (r < 22) begin
            it.mode = tea_pkg::MODE_QUERY;
            if (r >= 10)
               it.query_v = pool[$urandom_range(0, pool_n - 1)];
         end else if (r >= 26) begin
            it.mode   = tea_pkg::MODE_EDGE;
            it.from_v = pool[$urandom_range(0, pool_n - 1)];
            it.to_v   = pool[$urandom_range(0, pool_n - 1)];
            if (r < 28)
               dep = longint'(win_end) + longint'($urandom_range(0, 3));
            else begin
               dep = t + longint'($urandom_range(0, int'(span / 30) + 1));
               t   = dep;
            end
            if (dep > longint'(TIME_TOP))
               dep = longint'(TIME_TOP);
            it.depart   = dep[tea_pkg::TIME_W-1:0];
            it.duration = rand_time(0, int'(span / 6) + 1);
         end
         stream_items.push_back(it);
      end
   endtask

   // many restarts, each followed by an edge from the source and a query, to run through the pass tag
   task automatic gen_restart_burst(input int reps);
      logic [tea_pkg::VTX_W-1:0] pool [8];
      int                        k;
      stream_item_type           it;
      for (k = 0; k < 8; k++)
         pool[k] = rand_vtx();
      for (k = 0; k < reps; k++) begin
         it = rand_item();
         it.mode = tea_pkg::MODE_RESTART;
         stream_items.push_back(it);
         it = rand_item();
         it.mode     = tea_pkg::MODE_EDGE;
         it.from_v   = src_vtx;
         it.to_v     = pool[$urandom_range(0, 7)];
         it.depart   = win_start + rand_time(0, 50);
         it.duration = rand_time(0, 50);
         stream_items.push_back(it);
         it = rand_item();
         it.mode    = tea_pkg::MODE_QUERY;
         it.query_v = pool[$urandom_range(0, 7)];
         stream_items.push_back(it);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tea_pkg::REG_SOURCE_VERTEX: src_vtx   = val[tea_pkg::VTX_W-1:0];
         tea_pkg::REG_WINDOW_START:  win_start = val[tea_pkg::TIME_W-1:0];
         tea_pkg::REG_WINDOW_END:    win_end   = val[tea_pkg::TIME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_window(input logic [tea_pkg::VTX_W-1:0] vs,
                                 input logic [tea_pkg::TIME_W-1:0] ws,
                                 input logic [tea_pkg::TIME_W-1:0] we);
      csr_write(tea_pkg::REG_SOURCE_VERTEX, {22'd0, vs});
      csr_write(tea_pkg::REG_WINDOW_START, {1'b0, ws});
      csr_write(tea_pkg::REG_WINDOW_END, {1'b0, we});
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (stream_items.size() != 0 || req_valid || pending_answers.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : req_drive
      stream_item_type it;
      logic            offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid && !req_took;
         if (!offer) begin
            if (tx_wait > 0) begin
               tx_wait--;
            end else if (stream_items.size() > 0) begin
               it = stream_items.pop_front();
               req_mode         <= it.mode;
               req_from_vertex  <= it.from_v;
               req_to_vertex    <= it.to_v;
               req_depart_time  <= it.depart;
               req_duration     <= it.duration;
               req_query_vertex <= it.query_v;
               offer   = 1'b1;
               tx_wait = tx_idle_en ? pick_gap() : 0;
            end
         end
         req_valid <= offer;
      end
   end

   // result receiver
   always @(negedge clock) begin : rsp_drive
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_stall_done != long_stall_asks) begin
         long_stall_done++;
         rx_wait = LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rx_wait = rx_idle_en ? pick_gap() : 0;
      end
   end

   // beat monitor: check results, predict accepted requests
   always @(posedge clock) begin : beat_monitor
      stream_item_type it;
      answer_type      want;
      answer_type      fresh;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %0h", $time,
                        {rsp_reached, rsp_arrival_time, rsp_improved, rsp_closed});
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               check_field("reached", 32'(want.reached), 32'(rsp_reached));
               check_field("arrival_time", 32'(want.arrival), 32'(rsp_arrival_time));
               check_field("improved", 32'(want.improved), 32'(rsp_improved));
               check_field("closed", 32'(want.closed), 32'(rsp_closed));
            end
         end
         if (req_valid && req_ready) begin
            it = '{req_mode, req_from_vertex, req_to_vertex, req_depart_time,
                   req_duration, req_query_vertex};
            relax_and_answer(it, fresh);
            pending_answers.push_back(fresh);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [tea_pkg::VTX_W-1:0]  vs;
      logic [tea_pkg::TIME_W-1:0] ws;
      logic [tea_pkg::TIME_W-1:0] we;
      int                         ph;
      foreach (arr_mem[i]) begin
         arr_mem[i]   = '0;
         reach_mem[i] = 1'b0;
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed part, reset window
      push_item(tea_pkg::MODE_EDGE, 10'd0, 10'd5, 31'd10, 31'd5, 10'd0); // before any restart
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'd0);
      push_item(tea_pkg::MODE_RESTART, 10'd0, 10'd0, 31'd0, 31'd0, 10'd0);
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'd0);
      push_item(tea_pkg::MODE_EDGE, 10'd0, 10'd1, 31'd0, 31'd0, 10'd0);
      push_item(tea_pkg::MODE_EDGE, 10'd0, 10'd2, 31'd5, 31'd10, 10'd0);
      push_item(tea_pkg::MODE_EDGE, 10'd1, 10'd2, 31'd3, 31'd2, 10'd0);  // lowers arrival
      push_item(tea_pkg::MODE_EDGE, 10'd1, 10'd2, 31'd4, 31'd7, 10'd0);  // no gain
      push_item(tea_pkg::MODE_EDGE, 10'd2, 10'd3, 31'd4, 31'd1, 10'd0);  // departs too early
      push_item(tea_pkg::MODE_EDGE, 10'd3, 10'd4, 31'd9, 31'd1, 10'd0);  // unreached source
      push_item(tea_pkg::MODE_EDGE, 10'd0, 10'h3ff, TIME_TOP - 31'd1, 31'd1, 10'd0);
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'h3ff);
      push_item(tea_pkg::MODE_EDGE, 10'h3ff, 10'd5, TIME_TOP, TIME_TOP, 10'd0); // closes
      push_item(tea_pkg::MODE_EDGE, 10'd0, 10'd6, 31'd1, 31'd1, 10'd0);  // ignored once closed
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'd2);
      push_item(MODE_UNUSED, 10'h2aa, 10'h155, 31'h5555_5555, 31'h2aaa_aaaa, 10'h3ff);
      push_item(tea_pkg::MODE_RESTART, 10'h3ff, 10'h3ff, TIME_TOP, TIME_TOP, 10'h3ff);
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'h3ff); // stale entry
      push_item(tea_pkg::MODE_QUERY, 10'd0, 10'd0, 31'd0, 31'd0, 10'd0);
      wait_drained();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin vs = 10'h3ff; ws = '0; we = TIME_TOP; end
            1: begin vs = rand_vtx(); ws = TIME_TOP - 31'd1000; we = TIME_TOP; end
            2: begin vs = rand_vtx(); ws = TIME_TOP; we = '0; end
            3: begin vs = '0; ws = '0; we = '0; end
            default: begin
               vs = rand_vtx();
               ws = rand_time(0, 100000);
               we = ws + rand_time(20, 3000);
            end
         endcase
         program_window(vs, ws, we);
         tx_idle_en = (ph % 3 != 1);
         rx_idle_en = (ph % 3 != 2);
         if (ph == 1)
            long_stall_asks++;
         gen_walk((ph == 2 || ph == 3) ? 60 : ((ph < 2) ? 100 : 190), $urandom_range(3, 24));
         wait_drained();
      end

      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      ws = rand_time(0, 1000);
      program_window(rand_vtx(), ws, ws + 31'd500);
      gen_restart_burst(200);
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
